>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of the bit packer.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/hbp_pkg.sv
// Package for the Huffman bit packer: function codes, widths, table entry types.
// Depends on nothing.
`default_nettype none

package hbp_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int CODE_W       = 16;
    localparam int LEN_W        = 5;
    localparam int SYM_W        = 8;
    localparam int TABLE_DEPTH  = 256;
    localparam int EFF_MAX_LEN  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int PEND_W       = 7;
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int FIFO_DEPTH   = 4;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } code_entry_t;

    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  addr;
        code_entry_t       entry;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [SYM_W-1:0]  addr;
    } tbl_rd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_word_t;

endpackage

`default_nettype wire

>>> rtl/hbp_code_table.sv
// Code table: 256-entry synchronous memory; read data is registered and appears in the cycle after the read.
// Per-entry valid bits cleared at reset make unwritten entries read as zero.
// Depends on hbp_pkg.
`default_nettype none

module hbp_code_table (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire hbp_pkg::tbl_wr_t wr,
    input  wire hbp_pkg::tbl_rd_t rd,
    output hbp_pkg::code_entry_t rd_data
);

    hbp_pkg::code_entry_t                  mem [hbp_pkg::TABLE_DEPTH];
    logic [hbp_pkg::TABLE_DEPTH-1:0]       valid_reg;
    hbp_pkg::code_entry_t                  rd_data_reg;
    logic                                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> rtl/huffman_bit_packer_top.sv
// Huffman bit packer top: table lookup stage, packing stage, 4-word output queue.
// Path: an accepted encode or flush is registered in the lookup stage, then packed into the output queue.
// Throughput: 1 item per cycle; the queue drains 1 word per cycle while out_stall is low, and
// an item in the packing stage stalls input whenever the queue holds more than two words.
// Reset: asynchronous, active low; clears table valid bits, pending bits and queue.
`default_nettype none

module huffman_bit_packer_top (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire  [1:0] func,
    input  wire  [7:0] symbol,
    input  wire [15:0] code_bits,
    input  wire  [4:0] code_len,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] packed_byte,
    output logic       last
);

    localparam int ACC_W  = hbp_pkg::ACC_W;
    localparam int PEND_W = hbp_pkg::PEND_W;

    logic                   in_acc;
    hbp_pkg::tbl_wr_t       tbl_wr;
    hbp_pkg::tbl_rd_t       tbl_rd;
    hbp_pkg::code_entry_t   tbl_data;

    logic [4:0]             len_sat;
    logic [15:0]            code_mask;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_flush_reg;
    logic                   s1_fire;

    logic [PEND_W-1:0]      pend_reg;
    logic [PEND_W-1:0]      pend_next;
    logic [2:0]             pcnt_reg;
    logic [2:0]             pcnt_next;

    logic [ACC_W-1:0]       acc;
    logic [4:0]             total;
    logic [1:0]             push_n;
    hbp_pkg::out_word_t     w0;
    hbp_pkg::out_word_t     w1;

    hbp_pkg::out_word_t     fifo [hbp_pkg::FIFO_DEPTH];
    logic [1:0]             wr_ptr_reg;
    logic [1:0]             rd_ptr_reg;
    logic [2:0]             cnt_reg;
    logic                   pop;

    assign s1_fire  = s1_valid_reg && (cnt_reg <= 3'd2);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        len_sat = (code_len > hbp_pkg::EFF_MAX_LEN) ? 5'(hbp_pkg::EFF_MAX_LEN) : code_len;
        for (int i = 0; i < 16; i++)
        begin
            code_mask[i] = (5'(i) < len_sat);
        end
    end

    always_comb
    begin
        tbl_wr.en          = in_acc && (func == hbp_pkg::FUNC_LOAD);
        tbl_wr.addr        = symbol;
        tbl_wr.entry.len   = len_sat;
        tbl_wr.entry.code  = code_bits & code_mask;
        tbl_rd.en          = in_acc && (func == hbp_pkg::FUNC_ENCODE);
        tbl_rd.addr        = symbol;
    end

    hbp_code_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (tbl_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = (func == hbp_pkg::FUNC_ENCODE) || (func == hbp_pkg::FUNC_FLUSH);
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        acc       = ({{(ACC_W-PEND_W){1'b0}}, pend_reg} << tbl_data.len)
                    | {{(ACC_W-16){1'b0}}, tbl_data.code};
        total     = {2'b00, pcnt_reg} + tbl_data.len;
        push_n    = 2'd0;
        pend_next = pend_reg;
        pcnt_next = pcnt_reg;
        w0.data   = 8'(acc >> (total - 5'd8));
        w0.last   = 1'b1;
        w1.data   = 8'(acc >> (total - 5'd16));
        w1.last   = 1'b1;
        if (s1_fire)
        begin
            if (s1_flush_reg)
            begin
                if (pcnt_reg != 3'd0)
                begin
                    w0.data   = 8'({1'b0, pend_reg} << (4'd8 - {1'b0, pcnt_reg}));
                    push_n    = 2'd1;
                    pend_next = '0;
                    pcnt_next = 3'd0;
                end
            end
            else if (tbl_data.len != 5'd0)
            begin
                if (total >= 5'd16)
                begin
                    push_n  = 2'd2;
                    w0.last = 1'b0;
                end
                else if (total >= 5'd8)
                begin
                    push_n = 2'd1;
                end
                pcnt_next = total[2:0];
                pend_next = acc[PEND_W-1:0] & 7'((8'd1 << total[2:0]) - 8'd1);
            end
        end
    end

    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_flush_reg <= (func == hbp_pkg::FUNC_FLUSH);
        end
        if (push_n != 2'd0)
        begin
            fifo[wr_ptr_reg] <= w0;
        end
        if (push_n == 2'd2)
        begin
            fifo[wr_ptr_reg + 2'd1] <= w1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pend_reg     <= '0;
            pcnt_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            pend_reg     <= pend_next;
            pcnt_reg     <= pcnt_next;
            wr_ptr_reg   <= wr_ptr_reg + push_n;
            rd_ptr_reg   <= rd_ptr_reg + {1'b0, pop};
            cnt_reg      <= cnt_reg + {1'b0, push_n} - {2'b00, pop};
        end
    end

    assign out_valid   = (cnt_reg != 3'd0);
    assign packed_byte = fifo[rd_ptr_reg].data;
    assign last        = fifo[rd_ptr_reg].last;

endmodule

`default_nettype wire

>>> rtl/hbp_checker.sv
// Port-level checker for huffman_bit_packer_top, attached by bind.
// Depends on hbp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hbp_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire  [1:0] func,
    input wire        out_valid,
    input wire        out_stall,
    input wire  [7:0] packed_byte,
    input wire        last
);

    logic in_acc_work;
    logic out_hold;

    assign in_acc_work = in_valid && !in_stall
                         && ((func == hbp_pkg::FUNC_ENCODE) || (func == hbp_pkg::FUNC_FLUSH));
    assign out_hold    = out_valid && out_stall;

    `HBP_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_hold, out_valid)
    `HBP_ASSERT_NEXT(a_out_word_holds, clk, rst_n, out_hold, $stable(packed_byte) && $stable(last))
    `HBP_ASSERT_NOW(a_stall_needs_backlog, clk, rst_n, in_stall, out_valid)
    `HBP_ASSERT_NOW(a_output_has_cause, clk, rst_n, $rose(out_valid), $past(in_acc_work, 2))

endmodule

bind huffman_bit_packer_top hbp_checker u_hbp_checker (.*);

`default_nettype wire
